@@ design/load_store_address_patcher_defines.svh @@
// Assertion macros shared by the address patcher RTL.
// No dependencies; included by lsap_core, the module that carries concurrent checks.
`ifndef LOAD_STORE_ADDRESS_PATCHER_DEFINES_SVH
`define LOAD_STORE_ADDRESS_PATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSAP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSAP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lsap_pkg.sv @@
// Types and constants for the load/store address patcher.
// No dependencies; used by every module of the block by scoped names.
package lsap_pkg;

    localparam int WORD_W  = 16;
    localparam int SIZE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WORD_W-1:0] OPC_MASK  = 16'hFE0F;
    localparam logic [WORD_W-1:0] OPC_LOAD  = 16'h9000;
    localparam logic [WORD_W-1:0] OPC_STORE = 16'h9200;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NEW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd1;

    typedef struct packed {
        logic [WORD_W-1:0] old_address;
        logic [WORD_W-1:0] new_address;
        logic [SIZE_W-1:0] value_size;
    } cfg_t;

    typedef struct packed {
        logic              last;
        logic [WORD_W-1:0] word;
    } item_t;

    typedef struct packed {
        logic               last;
        logic               patched;
        logic [COUNT_W-1:0] total;
        logic [WORD_W-1:0]  word;
    } result_t;

endpackage

@@ design/load_store_address_patcher.sv @@
// Top level of the load/store address patcher: stream in, patched stream out.
// Depends on lsap_pkg, lsap_cfg_regs, lsap_in_reg and lsap_core.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  s_axis   | in        | s_tvalid/s_tready  | tdata in_word, tlast in_last
//  m_axis   | out       | m_tvalid/m_tready  | tdata out_word+replaced_total,
//           |           |                    | tuser was_patched, tlast out_last
//  cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while m_tready is high; a beat taken on s_* passes through
// the input register, then the result register, before it shows on m_*. The scan/run
// decision is combinational compare and add logic. cfg_ready is always high.
// aresetn (synchronous) clears both valid bits, the run state and the count, and resets the
// config registers (value_size to 1). Stalls on m_tready back up through the result and input registers.
module load_store_address_patcher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] in_word
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [15:0] out_word, [31:16] replaced_total
    output logic                            m_tuser,   // [0] was_patched
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lsap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsap_pkg::CFG_DATA_W-1:0] cfg_data
);

    lsap_pkg::cfg_t    cfg;
    lsap_pkg::item_t   s_item;
    lsap_pkg::item_t   q_item;
    lsap_pkg::result_t result;
    logic              q_valid;
    logic              q_ready;

    assign cfg_ready = 1'b1;

    lsap_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign s_item.word = s_tdata;
    assign s_item.last = s_tlast;

    lsap_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    lsap_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {result.total, result.word};
    assign m_tuser = result.patched;
    assign m_tlast = result.last;

endmodule

@@ design/lsap_cfg_regs.sv @@
// Configuration register file of the address patcher.
// Depends on lsap_pkg; writes with an index outside the list are dropped.
module lsap_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [lsap_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lsap_pkg::CFG_DATA_W-1:0] wr_data,
    output lsap_pkg::cfg_t                  cfg
);

    lsap_pkg::cfg_t cfg_reg;
    lsap_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                lsap_pkg::CFG_IDX_OLD:  cfg_next.old_address = wr_data;
                lsap_pkg::CFG_IDX_NEW:  cfg_next.new_address = wr_data;
                lsap_pkg::CFG_IDX_SIZE: cfg_next.value_size  = wr_data[lsap_pkg::SIZE_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.old_address <= '0;
            cfg_reg.new_address <= '0;
            cfg_reg.value_size  <= lsap_pkg::SIZE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/lsap_in_reg.sv @@
// Input register stage: captures one beat, frees itself when the core takes it.
// Depends on lsap_pkg for the item type.
module lsap_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lsap_pkg::item_t s_item,
    output logic            q_valid,
    input  logic            q_ready,
    output lsap_pkg::item_t q_item
);

    logic            valid_reg;
    lsap_pkg::item_t item_reg;

    assign s_ready = !valid_reg || q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (q_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

@@ design/lsap_core.sv @@
// Patch decision, scan/run state and result register of the address patcher.
// Depends on lsap_pkg and the assertion macros in the defines header.
`include "load_store_address_patcher_defines.svh"

module lsap_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsap_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsap_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lsap_pkg::result_t out_result
);

    typedef enum logic [1:0] {
        PH_SCAN  = 2'd0,
        PH_SKIP  = 2'd1,
        PH_CHECK = 2'd2
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [lsap_pkg::WORD_W-1:0]     prev_word_reg, prev_word_next;
    logic                            have_prev_reg, have_prev_next;
    logic [lsap_pkg::SIZE_W-1:0]     run_idx_reg, run_idx_next;
    logic [lsap_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                            out_valid_reg;
    lsap_pkg::result_t               result_reg, result_next;

    logic                            advance;
    logic [lsap_pkg::WORD_W-1:0]     prev_op;
    logic                            follows;
    logic [lsap_pkg::WORD_W-1:0]     run_off;
    logic [lsap_pkg::WORD_W-1:0]     want_addr;
    logic [lsap_pkg::WORD_W-1:0]     patch_addr;
    logic [lsap_pkg::SIZE_W:0]       run_inc;
    logic [lsap_pkg::WORD_W-1:0]     word;
    logic                            patched;

    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    assign prev_op    = prev_word_reg & lsap_pkg::OPC_MASK;
    assign follows    = have_prev_reg &&
                        (prev_op == lsap_pkg::OPC_LOAD || prev_op == lsap_pkg::OPC_STORE);
    assign run_off    = {{(lsap_pkg::WORD_W-lsap_pkg::SIZE_W){1'b0}}, run_idx_reg};
    assign want_addr  = cfg.old_address + run_off;
    assign patch_addr = cfg.new_address + run_off;
    assign run_inc    = {1'b0, run_idx_reg} + {{lsap_pkg::SIZE_W{1'b0}}, 1'b1};

    always_comb begin
        phase_next = phase_reg;
        run_idx_next = run_idx_reg;
        count_next = count_reg;
        word = in_item.word;
        patched = 1'b0;

        unique case (phase_reg)
            PH_SKIP: begin
                phase_next = PH_CHECK;
            end
            PH_CHECK: begin
                if (in_item.word == want_addr && follows) begin
                    word = patch_addr;
                    patched = 1'b1;
                    // run ends once the incremented index reaches the (current) symbol size
                    if (run_inc >= {1'b0, cfg.value_size}) begin
                        phase_next = PH_SCAN;
                        run_idx_next = '0;
                    end else begin
                        phase_next = PH_SKIP;
                        run_idx_next = run_inc[lsap_pkg::SIZE_W-1:0];
                    end
                end else begin
                    phase_next = PH_SCAN;
                    run_idx_next = '0;
                end
            end
            default: begin
                // scan, and the unused code behaves as scan
                phase_next = PH_SCAN;
                if (in_item.word == cfg.old_address && follows) begin
                    word = cfg.new_address;
                    patched = 1'b1;
                    if (count_reg != {lsap_pkg::COUNT_W{1'b1}}) begin
                        count_next = count_reg + {{(lsap_pkg::COUNT_W-1){1'b0}}, 1'b1};
                    end
                    if (cfg.value_size > {{(lsap_pkg::SIZE_W-1){1'b0}}, 1'b1}) begin
                        phase_next = PH_SKIP;
                        run_idx_next = {{(lsap_pkg::SIZE_W-1){1'b0}}, 1'b1};
                    end
                end
            end
        endcase

        prev_word_next = word;
        have_prev_next = 1'b1;
        if (in_item.last) begin
            phase_next = PH_SCAN;
            run_idx_next = '0;
            have_prev_next = 1'b0;
        end

        result_next.word    = word;
        result_next.patched = patched;
        result_next.total   = count_next;
        result_next.last    = in_item.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SCAN;
            prev_word_reg <= '0;
            have_prev_reg <= 1'b0;
            run_idx_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg     <= phase_next;
                prev_word_reg <= prev_word_next;
                have_prev_reg <= have_prev_next;
                run_idx_reg   <= run_idx_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                result_reg    <= result_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    `LSAP_ASSERT_NEXT(a_count_monotonic, aclk, aresetn, 1'b1,
        count_reg >= $past(count_reg), "replacement count went down")
    `LSAP_ASSERT_NEXT(a_skip_passes, aclk, aresetn,
        advance && phase_reg == PH_SKIP && !in_item.last,
        !result_reg.patched && phase_reg == PH_CHECK, "skipped word was patched")
    `LSAP_ASSERT_NEXT(a_last_resets, aclk, aresetn, advance && in_item.last,
        phase_reg == PH_SCAN && !have_prev_reg && run_idx_reg == '0,
        "end of image left a run open")
    `LSAP_ASSERT_NOW(a_run_idx_scan, aclk, aresetn, phase_reg == PH_SCAN,
        run_idx_reg == '0, "run index set in scan phase")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for load_store_address_patcher: drives code-image beats and register writes,
// predicts every output beat in a scoreboard class and compares it field by field.
// Depends on lsap_pkg and the load_store_address_patcher RTL.

typedef enum logic [1:0] {
    SCANNING = 2'd0,
    SKIPPING = 2'd1,
    CHECKING = 2'd2
} scan_phase_t;

class patch_scoreboard;
    lsap_pkg::cfg_t                   regs;
    logic [lsap_pkg::WORD_W-1:0]      prev_word;
    bit                               have_prev;
    scan_phase_t                      phase;
    logic [lsap_pkg::SIZE_W-1:0]      run_idx;
    logic [lsap_pkg::COUNT_W-1:0]     patch_count;
    lsap_pkg::result_t                expected_q[$];
    int unsigned                      errors;

    function new();
        regs.old_address = '0;
        regs.new_address = '0;
        regs.value_size  = lsap_pkg::SIZE_RESET;
        prev_word        = '0;
        have_prev        = 1'b0;
        phase            = SCANNING;
        run_idx          = '0;
        patch_count      = '0;
        errors           = 0;
    endfunction

    function void write_register(logic [lsap_pkg::CFG_IDX_W-1:0] idx,
                                 logic [lsap_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lsap_pkg::CFG_IDX_OLD:  regs.old_address = data;
            lsap_pkg::CFG_IDX_NEW:  regs.new_address = data;
            lsap_pkg::CFG_IDX_SIZE: regs.value_size  = data[lsap_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endfunction

    // opcode test looks at the previous *output* word, patched or not
    function bit after_access();
        logic [lsap_pkg::WORD_W-1:0] op;
        op = prev_word & lsap_pkg::OPC_MASK;
        return have_prev && (op == lsap_pkg::OPC_LOAD || op == lsap_pkg::OPC_STORE);
    endfunction

    function void note_word(logic [lsap_pkg::WORD_W-1:0] w, logic last);
        lsap_pkg::result_t           exp;
        logic [lsap_pkg::WORD_W-1:0] want;
        exp.word    = w;
        exp.patched = 1'b0;
        exp.last    = last;
        want        = regs.old_address + 16'(run_idx);
        case (phase)
            SKIPPING: phase = CHECKING;
            CHECKING: begin
                if (w == want && after_access()) begin
                    exp.word    = regs.new_address + 16'(run_idx);
                    exp.patched = 1'b1;
                    run_idx     = run_idx + 8'd1;
                    if (run_idx >= regs.value_size) begin
                        phase   = SCANNING;
                        run_idx = '0;
                    end else begin
                        phase = SKIPPING;
                    end
                end else begin
                    phase   = SCANNING;
                    run_idx = '0;
                end
            end
            default: begin
                phase = SCANNING;
                if (w == regs.old_address && after_access()) begin
                    exp.word    = regs.new_address;
                    exp.patched = 1'b1;
                    if (patch_count != 16'hFFFF)
                        patch_count = patch_count + 16'd1;
                    if (regs.value_size > 8'd1) begin
                        phase   = SKIPPING;
                        run_idx = 8'd1;
                    end
                end
            end
        endcase
        prev_word = exp.word;
        have_prev = 1'b1;
        if (last) begin
            phase     = SCANNING;
            run_idx   = '0;
            have_prev = 1'b0;
        end
        exp.total = patch_count;
        expected_q.push_back(exp);
    endfunction

    task report_mismatch(string msg);
        errors++;
        // keep the log readable when something breaks badly
        if (errors <= 200)
            $display("%0t: %s", $time, msg);
    endtask

    task check_result(lsap_pkg::result_t got);
        lsap_pkg::result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, word %h", got.word));
            return;
        end
        want = expected_q.pop_front();
        if (got.word !== want.word)
            report_mismatch($sformatf("out_word %h, expected %h", got.word, want.word));
        if (got.patched !== want.patched)
            report_mismatch($sformatf("was_patched %b, expected %b (word %h)",
                                      got.patched, want.patched, want.word));
        if (got.total !== want.total)
            report_mismatch($sformatf("replaced_total %h, expected %h",
                                      got.total, want.total));
        if (got.last !== want.last)
            report_mismatch($sformatf("out_last %b, expected %b", got.last, want.last));
    endtask
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam logic [lsap_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic [15:0]                     s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tready  = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [lsap_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lsap_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [31:0]                     m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_ready;

    patch_scoreboard sb = new();

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int words_sent      = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;

    logic [15:0] cur_old  = '0;
    logic [7:0]  cur_size = lsap_pkg::SIZE_RESET;

    always #5 aclk = ~aclk;

    load_store_address_patcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(lsap_pkg::result_t'({m_tlast, m_tuser, m_tdata[31:16],
                                                 m_tdata[15:0]}));
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [15:0] w, input logic l);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w, l);
        words_sent++;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
    endtask

    // image boundaries fall at random inside traffic
    task automatic send_traffic_word(input logic [15:0] w);
        send_word(w, $urandom_range(0, 63) == 0);
    endtask

    function automatic logic [15:0] random_opcode();
        logic [15:0] base;
        base = $urandom_range(0, 1) ? lsap_pkg::OPC_STORE : lsap_pkg::OPC_LOAD;
        return base | (16'($urandom()) & ~lsap_pkg::OPC_MASK);
    endfunction

    function automatic logic [15:0] random_address();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    task automatic write_register(input logic [lsap_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lsap_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, data);
        if (idx == lsap_pkg::CFG_IDX_OLD)
            cur_old = data;
        else if (idx == lsap_pkg::CFG_IDX_SIZE)
            cur_size = data[7:0];
    endtask

    // back-to-back writes; index 3 is unmapped and must be ignored
    task automatic configure(input logic [15:0] old_addr, input logic [15:0] repl_addr,
                             input logic [7:0] size);
        write_register(lsap_pkg::CFG_IDX_OLD, old_addr);
        write_register(lsap_pkg::CFG_IDX_NEW, repl_addr);
        write_register(lsap_pkg::CFG_IDX_SIZE, {8'($urandom()), size});
        write_register(CFG_IDX_UNUSED, 16'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    // mostly opcode/address access runs, some corrupted, plus noise
    task automatic run_traffic(input int count);
        int          target;
        int          run_len;
        logic [15:0] addr;
        target = words_sent + count;
        while (words_sent < target) begin
            case ($urandom_range(0, 9))
                7:       send_traffic_word(random_opcode());
                8, 9:    send_traffic_word(16'($urandom()));
                default: begin
                    run_len = ($urandom_range(0, 39) == 0) ? int'(cur_size)
                                                           : $urandom_range(1, 4);
                    if (run_len == 0)
                        run_len = 1;
                    for (int k = 0; k < run_len; k++) begin
                        send_traffic_word(random_opcode());
                        addr = cur_old + 16'(k);
                        if ($urandom_range(0, 19) == 0)
                            addr = addr ^ (16'd1 << $urandom_range(0, 15));
                        send_traffic_word(addr);
                    end
                end
            endcase
        end
    endtask

    initial begin
        logic [7:0]  size;
        logic [15:0] old_addr;
        logic [15:0] repl_addr;
        int          setting;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // run of three with the replacement wrapping past 0xFFFF
        configure(16'h0100, 16'hFFFF, 8'd3);
        send_word(16'h0100, 1'b0);   // first word of an image never matches
        send_word(16'h9000, 1'b0);
        send_word(16'h0100, 1'b0);
        send_word(16'h93F0, 1'b0);   // skipped
        send_word(16'h0101, 1'b0);
        send_word(16'h91F0, 1'b0);
        send_word(16'h0102, 1'b0);   // run complete
        send_word(16'h91F0, 1'b0);
        send_word(16'h0100, 1'b0);
        send_word(16'h9000, 1'b0);
        send_word(16'h0100, 1'b0);   // failed check, not rescanned as a new match
        send_word(16'h9200, 1'b0);
        send_word(16'h0100, 1'b1);   // match on the last word, run cut off
        send_word(16'h0101, 1'b0);
        send_word(16'h9000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        wait_drained();

        // patched word becomes the opcode for the next one; size 0 starts no run
        configure(16'h9200, 16'h9000, 8'd0);
        send_word(16'h9000, 1'b0);
        send_word(16'h9200, 1'b0);
        send_word(16'h9200, 1'b0);
        send_word(16'h9200, 1'b1);
        wait_drained();

        configure(16'hFFFF, 16'h0000, 8'd1);
        send_word(16'h9200, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 50; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 50; end
                default: begin sender_idle_pct = 38; stall_pct = 38; end
            endcase
            for (int s = 0; s < 2; s++) begin
                setting   = p * 2 + s;
                old_addr  = random_address();
                repl_addr = random_address();
                case (setting)
                    0, 4:    size = 8'd255;
                    1:       size = 8'd0;
                    2:       size = 8'd1;
                    6:       size = 8'd2;
                    default: size = 8'($urandom_range(2, 6));
                endcase
                if (setting == 4) begin
                    old_addr  = 16'hFFFF;
                    repl_addr = 16'hFFFF;
                end else if (setting == 5) begin
                    old_addr  = 16'h0000;
                    repl_addr = 16'h0000;
                end
                wait_drained();
                configure(old_addr, repl_addr, size);
                if (setting == 0) begin
                    // long receiver hold-off while the sender keeps offering beats
                    run_traffic(100);
                    hold_requests <= hold_requests + 1;
                    run_traffic(130);
                end else if (setting == 3) begin
                    run_traffic(115);
                    wait_drained();
                    run_traffic(115);
                end else begin
                    run_traffic(230);
                end
            end
        end

        sender_idle_pct = 0;
        stall_pct       = 0;
        wait_drained();

        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
